// ===== hw/rtl/sud_pkg.sv =====
package sud_pkg;

    // One body character of a literal.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    // One decoded result.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       run_last;
        logic       literal_end;
        logic [1:0] error_code;
    } t_out_item;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_ESCAPE = 2'd1,
        ERR_RANGE  = 2'd2
    } t_err;

    // Everything one character produces: up to four bytes or one error result.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            is_err;
        t_err            err_code;
        logic            lit_last;
    } t_burst;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam logic [7:0] UTF8_LEAD2 = 8'b1100_0000;
    localparam logic [7:0] UTF8_LEAD3 = 8'b1110_0000;
    localparam logic [7:0] UTF8_LEAD4 = 8'b1111_0000;
    localparam logic [7:0] UTF8_CONT  = 8'b1000_0000;
    localparam logic [7:0] UTF8_MASK6 = 8'b0011_1111;

    localparam logic [31:0] CP_MAX = 32'h001F_FFFF;

endpackage

// ===== hw/rtl/string_escape_utf8_decoder.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_item  (char_code, last_char)
// output    out        o_out_valid / i_out_ready  o_out_item (byte_out .. error_code)
//
// One character is taken per cycle while the burst queue has room; the
// decoder updates its escape state in the cycle the item is accepted.
// A character yields zero to four result items, sent one per cycle while
// i_out_ready is high; a character that expands to n bytes gives n items.
// Each burst passes through the burst queue, then into the output register.
// Reset is synchronous and active low; it returns to plain character mode.
// A stalled output fills the two-entry burst queue, after which input stalls.
module string_escape_utf8_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sud_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sud_pkg::t_out_item o_out_item
);
    import sud_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   head_valid;
    t_burst burst;
    t_burst head;

    // The queue only needs to refuse input when both entries hold bursts.
    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    // Escape state machine and UTF-8 encoder: one character in, at most one burst out.
    sud_decoder u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_burst  (burst)
    );

    // Bursts wait here so the input keeps flowing while the output drains.
    sud_burst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_burst (burst),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // Splits each burst into single-byte items behind the output register.
    sud_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

    // An error item carries no byte and always closes its run and the literal.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error_code != ERR_NONE |->
            !o_out_item.byte_valid && o_out_item.run_last && o_out_item.literal_end)
        else $error("error item has wrong shape");

    // A missing byte only ever comes with an error code.
    a_nobyte_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_valid |-> o_out_item.error_code != ERR_NONE)
        else $error("item without byte and without error");

    // The literal can only close on the final item of a character.
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.literal_end |-> o_out_item.run_last)
        else $error("literal end before run end");

endmodule

// ===== hw/rtl/sud_decoder.sv =====
module sud_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  sud_pkg::t_in_item i_item,
    output logic              o_push,
    output sud_pkg::t_burst   o_burst
);
    import sud_pkg::*;

    typedef enum logic [4:0] {
        MODE_PLAIN = 5'b00001,
        MODE_SLASH = 5'b00010,
        MODE_HEXB  = 5'b00100,
        MODE_UNI   = 5'b01000,
        MODE_OCT   = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_utf8;

    t_mode       r_mode, n_mode;
    logic [3:0]  r_digits, n_digits;
    logic [31:0] r_accum, n_accum;
    logic        r_discard, n_discard;

    logic [7:0]  ch;
    logic        last;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        esc_ok;
    logic [7:0]  esc_val;
    logic        is_oct;
    logic [31:0] acc_hex;
    logic [31:0] acc_oct;
    logic [3:0]  digits_dec;
    t_utf8       utf8;
    logic        fire_bytes;
    logic        fire_err;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= "0" && c <= "9") begin
                d = c - "0";
                return {1'b1, d[3:0]};
            end else if (c >= "A" && c <= "F") begin
                d = c - "A" + 8'd10;
                return {1'b1, d[3:0]};
            end else if (c >= "a" && c <= "f") begin
                d = c - "a" + 8'd10;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

    function automatic logic [8:0] single_letter(input logic [7:0] c);
        unique case (c)
            "a":          return {1'b1, 8'h07};
            "b":          return {1'b1, 8'h08};
            "e":          return {1'b1, 8'h1B};
            "f":          return {1'b1, 8'h0C};
            "n":          return {1'b1, 8'h0A};
            "r":          return {1'b1, 8'h0D};
            "t":          return {1'b1, 8'h09};
            "v":          return {1'b1, 8'h0B};
            CH_BACKSLASH: return {1'b1, 8'h5C};
            8'h27:        return {1'b1, 8'h27};
            8'h22:        return {1'b1, 8'h22};
            default:      return 9'd0;
        endcase
    endfunction

    function automatic t_utf8 encode_utf8(input logic [20:0] cp);
        t_utf8 u;
        begin
            u = '0;
            if (cp < 21'h80) begin
                u.bytes[0] = {1'b0, cp[6:0]};
                u.last_idx = 2'd0;
            end else if (cp < 21'h800) begin
                u.bytes[0] = UTF8_LEAD2 | {3'b0, cp[10:6]};
                u.bytes[1] = UTF8_CONT | ({2'b0, cp[5:0]} & UTF8_MASK6);
                u.last_idx = 2'd1;
            end else if (cp < 21'h10000) begin
                u.bytes[0] = UTF8_LEAD3 | {4'b0, cp[15:12]};
                u.bytes[1] = UTF8_CONT | ({2'b0, cp[11:6]} & UTF8_MASK6);
                u.bytes[2] = UTF8_CONT | ({2'b0, cp[5:0]} & UTF8_MASK6);
                u.last_idx = 2'd2;
            end else begin
                u.bytes[0] = UTF8_LEAD4 | {5'b0, cp[20:18]};
                u.bytes[1] = UTF8_CONT | ({2'b0, cp[17:12]} & UTF8_MASK6);
                u.bytes[2] = UTF8_CONT | ({2'b0, cp[11:6]} & UTF8_MASK6);
                u.bytes[3] = UTF8_CONT | ({2'b0, cp[5:0]} & UTF8_MASK6);
                u.last_idx = 2'd3;
            end
            return u;
        end
    endfunction

    assign ch   = i_item.char_code;
    assign last = i_item.last_char;

    assign {hex_ok, hex_val} = hex_value(ch);
    assign {esc_ok, esc_val} = single_letter(ch);
    assign is_oct     = (ch[7:3] == 5'b00110);
    assign acc_hex    = {r_accum[27:0], hex_val};
    assign acc_oct    = {r_accum[28:0], ch[2:0]};
    assign digits_dec = r_digits - 4'd1;
    assign utf8       = encode_utf8(acc_hex[20:0]);

    always_comb begin
        n_mode     = r_mode;
        n_digits   = r_digits;
        n_accum    = r_accum;
        n_discard  = r_discard;
        fire_bytes = 1'b0;
        fire_err   = 1'b0;
        o_burst    = '0;
        o_burst.lit_last = last;

        if (i_accept) begin
            if (r_discard) begin
                if (last) begin
                    n_discard = 1'b0;
                end
                n_mode   = MODE_PLAIN;
                n_digits = 4'd0;
                n_accum  = 32'd0;
            end else begin
                unique case (r_mode)
                    MODE_SLASH: begin
                        if (esc_ok) begin
                            fire_bytes       = 1'b1;
                            o_burst.bytes[0] = esc_val;
                        end else if (ch == "x" || ch == "u" || ch == "U" || is_oct) begin
                            if (ch == "x") begin
                                n_mode   = MODE_HEXB;
                                n_digits = 4'd2;
                                n_accum  = 32'd0;
                            end else if (ch == "u") begin
                                n_mode   = MODE_UNI;
                                n_digits = 4'd4;
                                n_accum  = 32'd0;
                            end else if (ch == "U") begin
                                n_mode   = MODE_UNI;
                                n_digits = 4'd8;
                                n_accum  = 32'd0;
                            end else begin
                                n_mode   = MODE_OCT;
                                n_digits = 4'd2;
                                n_accum  = {29'd0, ch[2:0]};
                            end
                            if (last) begin
                                fire_err         = 1'b1;
                                o_burst.err_code = ERR_ESCAPE;
                            end
                        end else begin
                            fire_err         = 1'b1;
                            o_burst.err_code = ERR_ESCAPE;
                        end
                    end
                    MODE_HEXB, MODE_UNI: begin
                        if (!hex_ok || r_digits == 4'd0) begin
                            fire_err         = 1'b1;
                            o_burst.err_code = ERR_ESCAPE;
                        end else begin
                            n_accum  = acc_hex;
                            n_digits = digits_dec;
                            if (digits_dec == 4'd0) begin
                                if (r_mode == MODE_HEXB) begin
                                    fire_bytes       = 1'b1;
                                    o_burst.bytes[0] = acc_hex[7:0];
                                end else if (acc_hex > CP_MAX) begin
                                    fire_err         = 1'b1;
                                    o_burst.err_code = ERR_RANGE;
                                end else begin
                                    fire_bytes       = 1'b1;
                                    o_burst.bytes    = utf8.bytes;
                                    o_burst.last_idx = utf8.last_idx;
                                end
                            end else if (last) begin
                                fire_err         = 1'b1;
                                o_burst.err_code = ERR_ESCAPE;
                            end
                        end
                    end
                    MODE_OCT: begin
                        if (!is_oct || r_digits == 4'd0) begin
                            fire_err         = 1'b1;
                            o_burst.err_code = ERR_ESCAPE;
                        end else begin
                            n_accum  = acc_oct;
                            n_digits = digits_dec;
                            if (digits_dec == 4'd0) begin
                                fire_bytes       = 1'b1;
                                o_burst.bytes[0] = acc_oct[7:0];
                            end else if (last) begin
                                fire_err         = 1'b1;
                                o_burst.err_code = ERR_ESCAPE;
                            end
                        end
                    end
                    default: begin
                        if (ch == CH_BACKSLASH) begin
                            n_mode   = MODE_SLASH;
                            n_digits = 4'd0;
                            n_accum  = 32'd0;
                            if (last) begin
                                fire_err         = 1'b1;
                                o_burst.err_code = ERR_ESCAPE;
                            end
                        end else begin
                            fire_bytes       = 1'b1;
                            o_burst.bytes[0] = ch;
                        end
                    end
                endcase

                // Any result ends the escape in progress.
                if (fire_bytes || fire_err) begin
                    n_mode   = MODE_PLAIN;
                    n_digits = 4'd0;
                    n_accum  = 32'd0;
                end
                if (fire_err) begin
                    o_burst.is_err   = 1'b1;
                    o_burst.bytes    = '0;
                    o_burst.last_idx = 2'd0;
                    n_discard        = !last;
                end
            end
        end
    end

    assign o_push = fire_bytes || fire_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_PLAIN;
            r_digits  <= 4'd0;
            r_accum   <= 32'd0;
            r_discard <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_digits  <= n_digits;
            r_accum   <= n_accum;
            r_discard <= n_discard;
        end
    end

endmodule

// ===== hw/rtl/sud_burst_fifo.sv =====
module sud_burst_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sud_pkg::t_burst i_burst,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output sud_pkg::t_burst o_head
);
    import sud_pkg::*;

    t_burst                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QUEUE_CNT_W'(i_push) - QUEUE_CNT_W'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/sud_serializer.sv =====
module sud_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  sud_pkg::t_burst    i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sud_pkg::t_out_item o_out_item
);
    import sud_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       load;
    logic       at_end;

    assign load   = i_head_valid && (!r_valid || i_out_ready);
    assign at_end = i_head.is_err || (r_idx == i_head.last_idx);
    assign o_pop  = load && at_end;

    always_comb begin
        n_out             = '0;
        n_out.run_last    = at_end;
        n_out.literal_end = at_end && (i_head.is_err || i_head.lit_last);
        if (i_head.is_err) begin
            n_out.error_code = i_head.err_code;
        end else begin
            n_out.byte_out   = i_head.bytes[r_idx];
            n_out.byte_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_out;

endmodule

// ===== tb/sud_check_pkg.sv =====
`timescale 1ns / 100ps

package sud_check_pkg;

    import sud_pkg::*;

    // Escape decoding phases of the predictor.
    typedef enum logic [2:0] {
        DEC_TEXT,
        DEC_ESC,
        DEC_HEX,
        DEC_UNI,
        DEC_OCT
    } t_dec_mode;

    // Value of a hex digit in either case, or -1 if the character is not one.
    function automatic int hex_digit_value(logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch - "0");
        if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
        if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
        return -1;
    endfunction

    // Byte for a single-letter escape, or -1 if the letter has no meaning.
    function automatic int escape_byte_of(logic [7:0] ch);
        case (ch)
            "a":          return 8'h07;
            "b":          return 8'h08;
            "e":          return 8'h1B;
            "f":          return 8'h0C;
            "n":          return 8'h0A;
            "r":          return 8'h0D;
            "t":          return 8'h09;
            "v":          return 8'h0B;
            CH_BACKSLASH: return 8'h5C;
            8'h27:        return 8'h27;
            8'h22:        return 8'h22;
            default:      return -1;
        endcase
    endfunction

    class escape_scoreboard;
        t_dec_mode   mode;
        logic [3:0]  digits_left;
        logic [31:0] accum;
        bit          dropping;
        t_out_item   expected_bytes[$];
        int          mismatches;
        int          checked;
        int          error_results;

        function new();
            clear_escape();
            dropping = 1'b0;
        endfunction

        function void clear_escape();
            mode = DEC_TEXT;
            digits_left = '0;
            accum = '0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void emit_bytes(logic [3:0][7:0] b, int n, bit last);
            t_out_item r;
            for (int i = 0; i < n; i++) begin
                r.byte_out    = b[i];
                r.byte_valid  = 1'b1;
                r.run_last    = (i == n - 1);
                r.literal_end = (i == n - 1) && last;
                r.error_code  = ERR_NONE;
                expected_bytes.push_back(r);
            end
            clear_escape();
        endfunction

        function void emit_error(t_err code, bit last);
            t_out_item r;
            r.byte_out    = '0;
            r.byte_valid  = 1'b0;
            r.run_last    = 1'b1;
            r.literal_end = 1'b1;
            r.error_code  = code;
            expected_bytes.push_back(r);
            clear_escape();
            dropping = !last;
        endfunction

        function void emit_one(logic [7:0] value, bit last);
            logic [3:0][7:0] b;
            b = '0;
            b[0] = value;
            emit_bytes(b, 1, last);
        endfunction

        function void emit_code_point(logic [31:0] cp, bit last);
            logic [3:0][7:0] b;
            b = '0;
            if (cp > 32'h001F_FFFF) begin
                emit_error(ERR_RANGE, last);
            end else if (cp < 32'h80) begin
                emit_one(cp[7:0], last);
            end else if (cp < 32'h800) begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
                emit_bytes(b, 2, last);
            end else if (cp < 32'h1_0000) begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
                emit_bytes(b, 3, last);
            end else begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
                emit_bytes(b, 4, last);
            end
        endfunction

        // Advances the decoder by one accepted character and queues its results.
        function void note_char(t_in_item item);
            logic [7:0] ch;
            bit         last;
            int         v;
            ch = item.char_code;
            last = item.last_char;
            if (dropping) begin
                if (last) dropping = 1'b0;
                clear_escape();
                return;
            end
            case (mode)
                DEC_ESC: begin
                    v = escape_byte_of(ch);
                    if (v >= 0) begin
                        emit_one(v[7:0], last);
                        return;
                    end
                    if (ch == "x") begin
                        mode = DEC_HEX;
                        digits_left = 4'd2;
                    end else if (ch == "u") begin
                        mode = DEC_UNI;
                        digits_left = 4'd4;
                    end else if (ch == "U") begin
                        mode = DEC_UNI;
                        digits_left = 4'd8;
                    end else if (ch >= "0" && ch <= "7") begin
                        mode = DEC_OCT;
                        digits_left = 4'd2;
                    end else begin
                        emit_error(ERR_ESCAPE, last);
                        return;
                    end
                    accum = (mode == DEC_OCT) ? 32'(ch - "0") : 32'd0;
                    if (last) emit_error(ERR_ESCAPE, last);
                end
                DEC_HEX, DEC_UNI: begin
                    v = hex_digit_value(ch);
                    if (v < 0 || digits_left == 0) begin
                        emit_error(ERR_ESCAPE, last);
                        return;
                    end
                    accum = {accum[27:0], v[3:0]};
                    digits_left--;
                    if (digits_left == 0) begin
                        if (mode == DEC_HEX) emit_one(accum[7:0], last);
                        else emit_code_point(accum, last);
                    end else if (last) begin
                        emit_error(ERR_ESCAPE, last);
                    end
                end
                DEC_OCT: begin
                    if (ch < "0" || ch > "7" || digits_left == 0) begin
                        emit_error(ERR_ESCAPE, last);
                        return;
                    end
                    accum = {accum[28:0], 3'(ch - "0")};
                    digits_left--;
                    if (digits_left == 0) emit_one(accum[7:0], last);
                    else if (last) emit_error(ERR_ESCAPE, last);
                end
                default: begin
                    if (ch == CH_BACKSLASH) begin
                        clear_escape();
                        mode = DEC_ESC;
                        if (last) emit_error(ERR_ESCAPE, last);
                    end else begin
                        emit_one(ch, last);
                    end
                end
            endcase
        endfunction

        // Compares one accepted result with the oldest expected one.
        function void check_result(t_out_item got);
            t_out_item want;
            checked++;
            if (got.error_code != ERR_NONE) error_results++;
            if (expected_bytes.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result with nothing expected: byte=%02h valid=%0b err=%0d",
                             $time, got.byte_out, got.byte_valid, got.error_code);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.byte_out !== want.byte_out || got.byte_valid !== want.byte_valid ||
                got.run_last !== want.run_last || got.literal_end !== want.literal_end ||
                got.error_code !== want.error_code) begin
                if (mismatches < 10)
                    $display("%0t: mismatch expected byte=%02h valid=%0b run_last=%0b ",
                             $time, want.byte_out, want.byte_valid, want.run_last,
                             "end=%0b err=%0d, got byte=%02h valid=%0b run_last=%0b ",
                             want.literal_end, want.error_code,
                             got.byte_out, got.byte_valid, got.run_last,
                             "end=%0b err=%0d", got.literal_end, got.error_code);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Checks the escape decoder against a cycle-free predictor kept in the
// scoreboard. Literals are fed as items of one character; every accepted
// character advances the predictor, and every accepted result is compared
// with the oldest prediction.
module tb;

    import sud_pkg::*;
    import sud_check_pkg::*;

    // Kinds of pieces a random literal is made of.
    typedef enum int {
        SEG_PLAIN,
        SEG_LETTER,
        SEG_HEX,
        SEG_OCT,
        SEG_U4,
        SEG_U8
    } t_seg;

    localparam int RANDOM_CHARS = 350;
    // The receiver stops for a long while once this many characters are in.
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 40;
    // The sender waits here until every predicted result has come out.
    localparam int PAUSE_AT     = 120;
    // Neither side idles while the character count is in this window.
    localparam int CALM_FROM    = 150;
    localparam int CALM_TO      = 230;
    localparam int IDLE_PERCENT = 22;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    escape_scoreboard sb = new();

    t_in_item   stimulus[$];
    logic [7:0] lit[$];
    int         sent_count = 0;
    int         literal_count = 0;

    string_escape_utf8_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the handshake locks up.
    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic bit calm_window();
        return sent_count >= CALM_FROM && sent_count < CALM_TO;
    endfunction

    // Moves the characters gathered in lit into the stimulus as one literal,
    // with the final character flagged as the end of the body.
    task automatic close_literal();
        t_in_item item;
        foreach (lit[i]) begin
            item.char_code = lit[i];
            item.last_char = (i == lit.size() - 1);
            stimulus.push_back(item);
        end
        lit.delete();
        literal_count++;
    endtask

    // Picks a code point, leaning on the edges of the UTF-8 length classes.
    // A wide pick may also fall above the largest encodable value.
    function automatic logic [31:0] pick_code_point(bit wide);
        case ($urandom_range(wide ? 5 : 3))
            0: return $urandom_range(32'h7F);
            1: return $urandom_range(32'h7FF, 32'h80);
            2: return $urandom_range(32'hFFFF, 32'h800);
            3: begin
                case ($urandom_range(wide ? 8 : 4))
                    0:       return 32'h7F;
                    1:       return 32'h80;
                    2:       return 32'h7FF;
                    3:       return 32'h800;
                    4:       return 32'hFFFF;
                    5:       return 32'h1_0000;
                    6:       return 32'h1F_FFFF;
                    7:       return 32'h20_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            4:       return $urandom_range(32'h1F_FFFF, 32'h1_0000);
            default: return $urandom();
        endcase
    endfunction

    // A character that is wrong at the given place of an escape: right after
    // the backslash it starts no known escape, later it is not a valid digit.
    function automatic logic [7:0] bad_char(t_seg kind, int pos);
        logic [7:0] ch;
        bit         good;
        do begin
            ch = 8'($urandom_range(255));
            if (pos == 1)
                good = escape_byte_of(ch) >= 0 || ch == "x" || ch == "u" || ch == "U" ||
                       (ch >= "0" && ch <= "7");
            else if (kind == SEG_OCT)
                good = ch >= "0" && ch <= "7";
            else
                good = hex_digit_value(ch) >= 0;
        end while (good);
        return ch;
    endfunction

    // Appends one piece to the literal under construction. A corrupted
    // escape gets one bad character; a truncated one is cut short and is
    // meant to be the final piece of its literal.
    task automatic add_segment(t_seg kind, bit corrupt, bit truncate);
        logic [7:0]  esc[$];
        logic [7:0]  ch;
        logic [31:0] cp;
        logic [3:0]  nib;
        int          ndig;
        int          pos;
        int          cut;
        ndig = 0;
        cp = '0;
        case (kind)
            SEG_PLAIN: begin
                lit.push_back(8'($urandom_range(255)));
                return;
            end
            SEG_LETTER: begin
                do ch = 8'($urandom_range(255)); while (escape_byte_of(ch) < 0);
                esc = {CH_BACKSLASH, ch};
            end
            SEG_HEX: begin
                esc = {CH_BACKSLASH, 8'("x")};
                cp = $urandom_range(255);
                ndig = 2;
            end
            SEG_OCT: begin
                cp = $urandom_range(511);
                esc = {CH_BACKSLASH};
                for (int i = 2; i >= 0; i--) esc.push_back(8'("0") + 8'(cp[i*3 +: 3]));
            end
            SEG_U4: begin
                esc = {CH_BACKSLASH, 8'("u")};
                cp = pick_code_point(1'b0);
                ndig = 4;
            end
            default: begin
                esc = {CH_BACKSLASH, 8'("U")};
                cp = pick_code_point(1'b1);
                ndig = 8;
            end
        endcase
        // Hex digits, most significant first, each in a random case.
        for (int i = ndig - 1; i >= 0; i--) begin
            nib = cp[i*4 +: 4];
            if (nib < 10) esc.push_back(8'("0") + 8'(nib));
            else esc.push_back(($urandom_range(1) ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10);
        end
        if (corrupt) begin
            pos = $urandom_range(esc.size() - 1, 1);
            esc[pos] = bad_char(kind, pos);
        end
        if (truncate) begin
            cut = $urandom_range(esc.size() - 1, 1);
            esc = esc[0:cut-1];
        end
        foreach (esc[i]) lit.push_back(esc[i]);
    endtask

    // Mostly well-formed literals with random content; a few carry a bad
    // character somewhere in an escape or end in the middle of one.
    task automatic gen_literal();
        int   nseg;
        t_seg kind;
        nseg = $urandom_range(6, 1);
        for (int s = 0; s < nseg; s++) begin
            kind = ($urandom_range(9) < 3) ? SEG_PLAIN : t_seg'($urandom_range(SEG_U8, SEG_LETTER));
            add_segment(kind, $urandom_range(99) < 6, 1'b0);
        end
        if ($urandom_range(99) < 10)
            add_segment(t_seg'($urandom_range(SEG_U8, SEG_LETTER)), 1'b0, 1'b1);
        close_literal();
    endtask

    task automatic build_stimulus();
        // Plain extremes, a letter escape and a two-digit hex byte in mixed case.
        lit = {8'h00, 8'hFF, CH_BACKSLASH, 8'("n"), CH_BACKSLASH, 8'("x"), 8'("F"), 8'("f")};
        close_literal();
        // A lone backslash as the whole body: the escape is cut off at once.
        lit = {CH_BACKSLASH};
        close_literal();
        // Octal escape 377, the largest one that fits in a byte.
        lit = {CH_BACKSLASH, 8'("3"), 8'("7"), 8'("7")};
        close_literal();
        // Unknown escape letter: error, then the rest of the literal is dropped.
        lit = {CH_BACKSLASH, 8'("q"), 8'("a")};
        close_literal();
        // Short unicode escape that needs three bytes of UTF-8.
        lit = {CH_BACKSLASH, 8'("u"), 8'("2"), 8'("0"), 8'("A"), 8'("C")};
        close_literal();
        while (stimulus.size() < RANDOM_CHARS) gen_literal();
    endtask

    // Offers characters one per cycle while the block is ready, with random gaps.
    // Each accepted item is handed to the scoreboard in the same step it is seen.
    task automatic drive_chars();
        bit pause_done;
        pause_done = 1'b0;
        while (1) begin
            @(posedge clk);
            if (in_valid && in_ready) begin
                sb.note_char(in_item);
                sent_count++;
            end
            if (sent_count == stimulus.size()) begin
                in_valid <= 1'b0;
                break;
            end
            // An offered item stays put until it is taken.
            if (in_valid && !in_ready) continue;
            if (!pause_done && sent_count == PAUSE_AT) begin
                in_valid <= 1'b0;
                if (sb.pending() == 0) pause_done = 1'b1;
                continue;
            end
            if (!calm_window() && $urandom_range(99) < IDLE_PERCENT) begin
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_item  <= stimulus[sent_count];
            end
        end
    endtask

    // Takes results with random stalls. Once the sender is far enough in, the
    // receiver refuses everything for a long stretch so the block backs up.
    task automatic serve_results();
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_result(out_item);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm_window() || $urandom_range(99) >= IDLE_PERCENT;
            end
        end
    endtask

    initial begin
        build_stimulus();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        fork
            serve_results();
        join_none
        drive_chars();
        // Drain what is still in flight, then wait on through the pipeline
        // to show any result that should not be there.
        for (int n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending() != 0) $display("%0d predicted results never came out", sb.pending());
        $display("Sent %0d characters in %0d literals; checked %0d results, %0d of them errors.",
                 sent_count, literal_count, sb.checked, sb.error_results);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sud_pkg.sv
hw/rtl/sud_decoder.sv
hw/rtl/sud_burst_fifo.sv
hw/rtl/sud_serializer.sv
hw/rtl/string_escape_utf8_decoder.sv
tb/sud_check_pkg.sv
tb/tb.sv
